FILE: rtl/prrs_pkg.sv
// Shared types, constants and operation codes of the priority round-robin scheduler.
package prrs_pkg;

    localparam int NUM_TASKS_DEF  = 64;
    localparam int NUM_LEVELS_DEF = 8;

    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_ADD      = 3'd1,
        OP_BLOCK    = 3'd2,
        OP_DELETE   = 3'd3,
        OP_PRIO     = 3'd4,
        OP_RESCHED  = 3'd5
    } t_op;

    localparam logic [1:0] ST_WAITING     = 2'd0;
    localparam logic [1:0] ST_SYNC_BLOCK  = 2'd1;
    localparam logic [1:0] ST_RUNNABLE    = 2'd2;
    localparam logic [1:0] ST_SCHEDULABLE = 2'd3;

    localparam logic [1:0] RC_OK      = 2'd0;
    localparam logic [1:0] RC_BAD     = 2'd1;
    localparam logic [1:0] RC_NOTHING = 2'd2;

    typedef struct packed {
        logic [2:0] operation;
        logic [5:0] task_id;
        logic       status_choice;
        logic [2:0] new_priority;
    } t_req;

    typedef struct packed {
        logic [5:0] chosen_task;
        logic       needs_message;
        logic [1:0] result_code;
    } t_rsp;

    // Datapath commands issued by the controller each cycle.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,      // capture request, read task tables
        CMD_DECIDE,     // evaluate preconditions, start removal or pick
        CMD_RM_READ,    // member read of the last slot returned
        CMD_RM_WRITE,   // move last member into freed slot
        CMD_APPEND,     // append task at its (new) level
        CMD_PICK_READ,  // member read of the round-robin pick returned
        CMD_FINISH      // write status, form the response
    } t_cmd;

    typedef struct packed {
        logic need_remove;
        logic need_append;
        logic need_pick;
    } t_status;

endpackage

FILE: rtl/priority_round_robin_scheduler.sv
// Top level of the multilevel priority round-robin scheduler.
//
// Usage: a request arrives on the i_req channel (valid/ready) carrying an
// operation, a task, a status choice and a priority. Exactly one response
// leaves on the o_rsp channel (valid/ready) for every accepted request.
// The block works on one request at a time. From acceptance to a valid
// response it steps through latch and decide; a removal then reads the
// last member and moves it, an append adds a step, a round-robin pick adds
// a member read, and a final step writes status and forms the response.
// These steps are set by the registered read ports of the member memory,
// the slot table and the task table. A new request is taken in the cycle
// after its predecessor's response is accepted.
// While the receiver stalls the response is held stable and no new
// request is accepted. Synchronous active-low reset empties every level,
// clears the current task and clears one flag per task, so that every
// task reads as waiting at priority zero until its entry is written; the
// member memory and slot table need no clearing since only written
// entries are ever read.
module priority_round_robin_scheduler import prrs_pkg::*; #(
    parameter int NUM_TASKS  = NUM_TASKS_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);
    t_cmd    cmd;
    t_status status;

    prrs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .o_in_ready(o_ready),
        .o_out_valid(o_valid), .i_out_ready(i_ready),
        .i_status(status), .o_cmd(cmd));

    prrs_dp #(.NUM_TASKS(NUM_TASKS), .NUM_LEVELS(NUM_LEVELS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(cmd), .i_req(i_req), .o_status(status), .o_rsp(o_rsp));
endmodule

FILE: rtl/prrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module prrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/prrs_ctrl.sv
// Sequencing state machine of the scheduler.
module prrs_ctrl import prrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_RM_READ, S_RM_WRITE, S_APPEND, S_PICK, S_FINISH, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_append, n_append;

    always_comb begin
        n_state  = r_state;
        n_append = r_append;
        o_cmd    = CMD_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LATCH;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_cmd    = CMD_DECIDE;
                n_append = i_status.need_append;
                if (i_status.need_remove) n_state = S_RM_READ;
                else if (i_status.need_append) n_state = S_APPEND;
                else if (i_status.need_pick) n_state = S_PICK;
                else n_state = S_FINISH;
            end
            S_RM_READ: begin
                o_cmd   = CMD_RM_READ;
                n_state = S_RM_WRITE;
            end
            S_RM_WRITE: begin
                o_cmd   = CMD_RM_WRITE;
                n_state = r_append ? S_APPEND : S_FINISH;
            end
            S_APPEND: begin
                o_cmd   = CMD_APPEND;
                n_state = S_FINISH;
            end
            S_PICK: begin
                o_cmd   = CMD_PICK_READ;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                o_cmd   = CMD_FINISH;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_append <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_append <= n_append;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

`ifndef NO_ASSERTIONS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("response dropped while stalled");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("ready during pending response");
    a_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd == CMD_LATCH |=> o_cmd == CMD_DECIDE)
        else $error("decide did not follow latch");
`endif
endmodule

FILE: rtl/prrs_dp.sv
// Scheduler tables and the update datapath.
module prrs_dp import prrs_pkg::*; #(
    parameter int NUM_TASKS  = NUM_TASKS_DEF,
    parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_req    i_req,
    output t_status o_status,
    output t_rsp    o_rsp
);
    localparam int TW = $clog2(NUM_TASKS);
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int MW = LW + TW;
    localparam int EW = 2 + LW;

    logic [CW-1:0]        r_count [NUM_LEVELS];
    logic [TW-1:0]        r_rr    [NUM_LEVELS];
    logic [NUM_TASKS-1:0] r_tvld;
    logic                 r_tvld_q;

    t_req          r_req;
    logic [TW-1:0] r_t;
    logic          r_valid;
    logic [LW-1:0] r_lv_new;
    logic [1:0]    r_code;
    logic          r_msg;
    logic [TW-1:0] r_chosen, r_cur, r_slot_s;
    logic [1:0]    r_new_st;
    logic          r_set_st, r_set_lv;

    // slot table RAM
    logic          slot_we;
    logic [TW-1:0] slot_waddr, slot_wdata, slot_rdata;
    // member RAM
    logic          mem_we;
    logic [MW-1:0] mem_waddr, mem_raddr;
    logic [TW-1:0] mem_wdata, mem_rdata;
    // task table RAM, one entry of {status, priority} per task
    logic          task_we;
    logic [TW-1:0] task_waddr, task_raddr;
    logic [EW-1:0] task_wdata, task_rdata;
    logic [1:0]    t_st;
    logic [LW-1:0] t_lv;

    prrs_ram #(.WIDTH(TW), .DEPTH(NUM_TASKS)) u_slot (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(slot_waddr), .i_wdata(slot_wdata),
        .i_raddr(i_req.task_id[TW-1:0]), .o_rdata(slot_rdata));

    prrs_ram #(.WIDTH(TW), .DEPTH(NUM_LEVELS * NUM_TASKS)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata));

    prrs_ram #(.WIDTH(EW), .DEPTH(NUM_TASKS)) u_task (
        .i_clk(i_clk), .i_we(task_we), .i_waddr(task_waddr), .i_wdata(task_wdata),
        .i_raddr(task_raddr), .o_rdata(task_rdata));

    // The task table is read for the named task at latch time, for the picked
    // member during the pick read, and for the named task otherwise; unless a
    // pick is made, the named task's entry is on the read port from decide to finish.
    always_comb begin
        case (i_cmd)
            CMD_LATCH:     task_raddr = i_req.task_id[TW-1:0];
            CMD_PICK_READ: task_raddr = mem_rdata;
            default:       task_raddr = r_t;
        endcase
    end

    // Entries never written since reset read as waiting at priority zero.
    always_ff @(posedge i_clk) begin
        r_tvld_q <= r_tvld[task_raddr];
    end

    assign t_st = r_tvld_q ? task_rdata[EW-1:LW] : ST_WAITING;
    assign t_lv = r_tvld_q ? task_rdata[LW-1:0] : '0;

    // Highest non-empty level and its next round-robin index.
    logic [LW-1:0] hi_lv;
    logic          hi_any;
    logic [TW-1:0] hi_idx;
    always_comb begin
        hi_lv  = '0;
        hi_any = 1'b0;
        for (int k = 0; k < NUM_LEVELS; k++) begin
            if (r_count[k] != '0) begin
                hi_lv  = LW'(k);
                hi_any = 1'b1;
            end
        end
        if ({1'b0, r_rr[hi_lv]} + (TW+1)'(1) >= (TW+1)'(r_count[hi_lv])) hi_idx = '0;
        else hi_idx = r_rr[hi_lv] + TW'(1);
    end

    logic          active_now;
    logic [CW-1:0] cnt_old, cnt_new;
    always_comb begin
        active_now = t_st[1];
        cnt_old    = r_count[t_lv];
        cnt_new    = r_count[r_lv_new];
    end

    // Decision, evaluated in the decide cycle.
    logic d_rm, d_app, d_pick, d_hint, d_set;
    logic [1:0] d_code, d_st;
    logic       np_ok;
    always_comb begin
        np_ok  = (int'(r_req.new_priority) < NUM_LEVELS);
        d_rm   = 1'b0; d_app = 1'b0; d_pick = 1'b0; d_hint = 1'b0;
        d_set  = 1'b0; d_code = RC_OK; d_st = ST_WAITING;
        if (r_req.operation == OP_RESCHED) begin
            if (r_valid && active_now) d_hint = 1'b1;
            else if (hi_any) d_pick = 1'b1;
            else d_code = RC_NOTHING;
        end else if (r_req.operation > OP_RESCHED || !r_valid) begin
            d_code = RC_BAD;
        end else begin
            case (r_req.operation)
                OP_CREATE: begin
                    if (active_now) d_code = RC_BAD;
                    else d_set = 1'b1;
                end
                OP_ADD: begin
                    if (active_now || !np_ok) d_code = RC_BAD;
                    else begin
                        d_app = 1'b1; d_set = 1'b1;
                        d_st  = r_req.status_choice ? ST_SCHEDULABLE : ST_RUNNABLE;
                    end
                end
                OP_BLOCK: begin
                    if (!active_now) d_code = RC_BAD;
                    else begin
                        d_rm = 1'b1; d_set = 1'b1;
                        d_st = r_req.status_choice ? ST_SYNC_BLOCK : ST_WAITING;
                    end
                end
                OP_DELETE: begin
                    d_rm  = active_now;
                    d_set = 1'b1;
                end
                OP_PRIO: begin
                    if (!active_now || !np_ok) d_code = RC_BAD;
                    else begin
                        d_rm = 1'b1; d_app = 1'b1;
                    end
                end
                default: d_code = RC_BAD;
            endcase
        end
        // removal is skipped when the slot is stale, exactly as a guarded remove
        if (d_rm && (cnt_old == '0 || CW'(slot_rdata) >= cnt_old)) d_rm = 1'b0;
    end

    assign o_status.need_remove = d_rm;
    assign o_status.need_append = d_app;
    assign o_status.need_pick   = d_pick;

    always_comb begin
        slot_we    = 1'b0; slot_waddr = r_t; slot_wdata = '0;
        mem_we     = 1'b0; mem_waddr = {r_lv_new, cnt_new[TW-1:0]}; mem_wdata = r_t;
        mem_raddr  = {hi_lv, hi_idx};
        case (i_cmd)
            CMD_DECIDE: begin
                if (d_pick) mem_raddr = {hi_lv, hi_idx};
                else mem_raddr = {t_lv, TW'(cnt_old - CW'(1))};
            end
            // The count is already decremented, so it indexes the last member.
            CMD_RM_READ: mem_raddr = {t_lv, cnt_old[TW-1:0]};
            CMD_RM_WRITE: begin
                mem_we     = 1'b1;
                mem_waddr  = {t_lv, r_slot_s};
                mem_wdata  = mem_rdata;
                slot_we    = 1'b1;
                slot_waddr = mem_rdata;
                slot_wdata = r_slot_s;
            end
            CMD_APPEND: begin
                mem_we     = (cnt_new < CW'(NUM_TASKS));
                slot_we    = mem_we;
                slot_wdata = cnt_new[TW-1:0];
            end
            default: ;
        endcase
    end

    // Status and priority of the named task are written back at finish; a
    // schedulable pick is made runnable there as well.
    always_comb begin
        task_we    = 1'b0;
        task_waddr = r_t;
        task_wdata = {t_st, t_lv};
        if (i_cmd == CMD_FINISH) begin
            if (r_set_st || r_set_lv) begin
                task_we    = 1'b1;
                task_wdata = {r_set_st ? r_new_st : t_st, r_set_lv ? r_lv_new : t_lv};
            end else if (r_chosen != '0 && t_st == ST_SCHEDULABLE) begin
                task_we    = 1'b1;
                task_waddr = r_chosen;
                task_wdata = {ST_RUNNABLE, t_lv};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_count[i] <= '0;
                r_rr[i]    <= '0;
            end
            r_tvld <= '0;
            r_cur  <= '0;
        end else begin
            if (task_we) r_tvld[task_waddr] <= 1'b1;
            case (i_cmd)
                CMD_LATCH: begin
                    r_req    <= i_req;
                    r_t      <= i_req.task_id[TW-1:0];
                    r_lv_new <= i_req.new_priority[LW-1:0];
                    r_valid  <= (i_req.task_id != '0)
                                && (int'(i_req.task_id) < NUM_TASKS);
                end
                CMD_DECIDE: begin
                    r_code   <= d_code;
                    r_set_st <= d_set;
                    r_set_lv <= d_app;
                    r_new_st <= d_st;
                    r_chosen <= d_hint ? r_t : '0;
                    r_slot_s <= slot_rdata;
                    if (d_pick) r_rr[hi_lv] <= hi_idx;
                    if (d_rm) r_count[t_lv] <= cnt_old - CW'(1);
                end
                CMD_APPEND: begin
                    if (cnt_new < CW'(NUM_TASKS)) r_count[r_lv_new] <= cnt_new + CW'(1);
                end
                CMD_PICK_READ: r_chosen <= mem_rdata;
                CMD_FINISH: begin
                    r_msg <= (r_chosen != '0) && (t_st == ST_SCHEDULABLE);
                    if (r_chosen != '0) r_cur <= r_chosen;
                end
                default: ;
            endcase
        end
    end

    assign o_rsp.chosen_task   = 6'(r_chosen);
    assign o_rsp.needs_message = r_msg;
    assign o_rsp.result_code   = r_code;

    logic unused;
    assign unused = ^r_cur;

`ifndef NO_ASSERTIONS
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_FINISH && r_code != RC_OK |-> r_chosen == '0)
        else $error("task chosen with error code");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_RM_WRITE |-> r_count[t_lv] < CW'(NUM_TASKS))
        else $error("count overflow on removal");
    a_app: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd == CMD_APPEND |-> cnt_new < CW'(NUM_TASKS))
        else $error("append to a full level");
`endif
endmodule
